// ===== src/lltd_pkg.sv =====
// ============================================================================
// lltd_pkg: shared codes for the least-loaded task dispatcher
// Request kinds, result status codes and fixed field widths.
// ============================================================================
`default_nettype none

package lltd_pkg;

  // request kinds
  localparam logic [1:0] KIND_DISPATCH = 2'd0;
  localparam logic [1:0] KIND_TAKE     = 2'd1;
  localparam logic [1:0] KIND_FINISH   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_PLACED  = 3'd0;
  localparam logic [2:0] ST_TAKEN   = 3'd1;
  localparam logic [2:0] ST_IDLE    = 3'd2;
  localparam logic [2:0] ST_NOREB   = 3'd3;
  localparam logic [2:0] ST_MOVED   = 3'd4;
  localparam logic [2:0] ST_REFUSED = 3'd5;

  // fixed field widths
  localparam int KIND_W  = 2;
  localparam int WRK_W   = 3;
  localparam int STAT_W  = 3;
  localparam int TCNT_W  = 7;
  localparam int BUSY_W  = 4;
  localparam int THR_W   = 7;

  // rebalance move cap per finish request
  localparam int MV_W = 7;
  localparam logic [MV_W-1:0] MOVE_CAP = 7'd64;

  localparam logic [THR_W-1:0] THR_RESET = 7'd10;

endpackage

`default_nettype wire

// ===== src/least_loaded_task_dispatcher_core.sv =====
// ============================================================================
// least_loaded_task_dispatcher_core: per-worker load tracking and dispatch
// Pending counts live in a one-port-read, one-port-write synchronous memory.
// ============================================================================
// Take and finish read the count, then emit; a take finding zero rescans all
//   counts, dispatch scans unless the hinted worker holds at most one task.
// Rebalance: each move runs a target choice; scans read one count a cycle.
// Throughput: one request at a time; the next request is taken once the
//   current one has handed its final result to the output register.
// Reset: sync, active low; counts read zero via valid bits, hint 0, busiest none.
`default_nettype none

module least_loaded_task_dispatcher_core #(
  parameter int NUM_WORKERS = 8,
  parameter int MAX_PENDING = 127
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [lltd_pkg::THR_W-1:0]    cfg_wr_data,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lltd_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [lltd_pkg::WRK_W-1:0]    in_worker,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [lltd_pkg::STAT_W-1:0]        out_status,
  output logic [lltd_pkg::WRK_W-1:0]         out_target_worker,
  output logic [lltd_pkg::TCNT_W-1:0]        out_target_count,
  output logic [lltd_pkg::BUSY_W-1:0]        out_busiest_worker,
  output logic                               out_last
);

  import lltd_pkg::*;

  localparam int WI = $clog2(NUM_WORKERS);        // worker index bits
  localparam int WB = $clog2(NUM_WORKERS + 1);    // busiest, holds "none"
  localparam int CW = $clog2(MAX_PENDING + 1);    // count bits

  localparam logic [WB-1:0] BUSY_NONE = WB'(NUM_WORKERS);
  localparam logic [WI-1:0] IDX_LAST  = WI'(NUM_WORKERS - 1);
  localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_PENDING);
  localparam logic [CW-1:0] CNT_ONE   = CW'(1);

  typedef enum logic [3:0] {
    S_IDLE,      // wait for a request, issue first read
    S_TAKE,      // count of worker back: decrement or go idle
    S_BZ,        // busiest recompute scan
    S_FIN,       // finish: decide on rebalance
    S_RB_DEC,    // rebalance: pull one task off the shedding worker
    S_CH_START,  // target choice: read hinted worker
    S_CH_HINT,   // hinted count back
    S_CH_SCAN,   // scan from worker 0
    S_APPLY,     // place or refuse the task
    S_EMIT       // hand the result to the output register
  } state_t;

  state_t state_r, state_nxt;

  // ---------------------------------------------------------------------------
  // Count memory: one write and one registered read per cycle. The sequencer
  // never reads an entry at the edge it is written, so no forwarding needed.
  // ---------------------------------------------------------------------------
  logic [CW-1:0]          cnt_mem [NUM_WORKERS];
  logic [NUM_WORKERS-1:0] cnt_vld_r;
  logic                   mem_we, mem_re;
  logic [WI-1:0]          mem_wa, mem_ra;
  logic [CW-1:0]          mem_wd;
  logic [CW-1:0]          rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= cnt_vld_r[mem_ra] ? cnt_mem[mem_ra] : '0;
    end
  end

  // unwritten entries read as zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (mem_we) begin
      cnt_vld_r[mem_wa] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [WI-1:0]     hint_r, hint_nxt;
  logic [WB-1:0]     busiest_r, busiest_nxt;
  logic [WRK_W-1:0]  w_r, w_nxt;           // request worker, as given
  logic              reb_r, reb_nxt;       // choice runs for a rebalance move
  logic [WI-1:0]     idx_r, idx_nxt;       // scan address of rd_data_r
  logic [WI-1:0]     pick_r, pick_nxt;
  logic [CW-1:0]     best_r, best_nxt;
  logic [CW-1:0]     top_r, top_nxt;
  logic [WB-1:0]     who_r, who_nxt;
  logic [CW-1:0]     shed_r, shed_nxt;     // live count of the shedding worker
  logic [MV_W-1:0]   moves_r, moves_nxt;   // moves still to do

  // pending result
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [WRK_W-1:0]  res_tw_r, res_tw_nxt;
  logic [CW-1:0]     res_tc_r, res_tc_nxt;
  logic              res_last_r, res_last_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [WRK_W-1:0]  out_tw_r, out_tw_nxt;
  logic [TCNT_W-1:0] out_tc_r, out_tc_nxt;
  logic [BUSY_W-1:0] out_busy_r, out_busy_nxt;
  logic              out_last_r, out_last_nxt;

  logic          out_free;
  logic [WI-1:0] w_idx;
  logic          in_absent;
  logic [CW-1:0] half_cnt;
  logic [MV_W-1:0] move_cnt;
  logic          refuse, last_move;

  assign out_free  = !out_valid_r || !out_stall;
  assign w_idx     = WI'(w_r);
  assign in_absent = 32'(in_worker) >= NUM_WORKERS;
  assign half_cnt  = rd_data_r >> 1;
  assign move_cnt  = (32'(half_cnt) > 32'(MOVE_CAP)) ? MOVE_CAP : MV_W'(half_cnt);
  assign refuse    = best_r >= CNT_MAX;
  assign last_move = reb_r && (moves_r == MV_W'(1));

  always_comb begin
    state_nxt      = state_r;
    thr_nxt        = cfg_wr_en ? cfg_wr_data : thr_r;
    hint_nxt       = hint_r;
    busiest_nxt    = busiest_r;
    w_nxt          = w_r;
    reb_nxt        = reb_r;
    idx_nxt        = idx_r;
    pick_nxt       = pick_r;
    best_nxt       = best_r;
    top_nxt        = top_r;
    who_nxt        = who_r;
    shed_nxt       = shed_r;
    moves_nxt      = moves_r;
    res_status_nxt = res_status_r;
    res_tw_nxt     = res_tw_r;
    res_tc_nxt     = res_tc_r;
    res_last_nxt   = res_last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_tw_nxt     = out_tw_r;
    out_tc_nxt     = out_tc_r;
    out_busy_nxt   = out_busy_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_wa         = w_idx;
    mem_wd         = '0;
    mem_re         = 1'b0;
    mem_ra         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          w_nxt        = in_worker;
          res_last_nxt = 1'b1;
          case (in_kind) inside
            KIND_DISPATCH: begin
              reb_nxt   = 1'b0;
              mem_re    = 1'b1;
              mem_ra    = hint_r;
              state_nxt = S_CH_HINT;
            end
            KIND_TAKE, KIND_FINISH: begin
              if (in_absent) begin
                res_status_nxt = ST_NOREB;
                res_tw_nxt     = in_worker;
                res_tc_nxt     = '0;
                state_nxt      = S_EMIT;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = WI'(in_worker);
                state_nxt = (in_kind == KIND_TAKE) ? S_TAKE : S_FIN;
              end
            end
            default: begin
              res_status_nxt = ST_NOREB;
              res_tw_nxt     = '0;
              res_tc_nxt     = '0;
              state_nxt      = S_EMIT;
            end
          endcase
        end
      end

      S_TAKE: begin
        if (rd_data_r == '0) begin
          hint_nxt  = w_idx;
          mem_re    = 1'b1;
          mem_ra    = '0;
          idx_nxt   = '0;
          top_nxt   = '0;
          who_nxt   = BUSY_NONE;
          state_nxt = S_BZ;
        end else begin
          mem_we         = 1'b1;
          mem_wa         = w_idx;
          mem_wd         = rd_data_r - CNT_ONE;
          res_status_nxt = ST_TAKEN;
          res_tw_nxt     = w_r;
          res_tc_nxt     = rd_data_r - CNT_ONE;
          state_nxt      = S_EMIT;
        end
      end

      S_BZ: begin
        if (rd_data_r > top_r) begin
          top_nxt = rd_data_r;
          who_nxt = WB'(idx_r);
        end
        if (idx_r == IDX_LAST) begin
          busiest_nxt    = (rd_data_r > top_r) ? WB'(idx_r) : who_r;
          res_status_nxt = ST_IDLE;
          res_tw_nxt     = w_r;
          res_tc_nxt     = '0;
          state_nxt      = S_EMIT;
        end else begin
          idx_nxt = idx_r + WI'(1);
          mem_re  = 1'b1;
          mem_ra  = idx_r + WI'(1);
        end
      end

      S_FIN: begin
        res_status_nxt = ST_NOREB;
        res_tw_nxt     = w_r;
        res_tc_nxt     = rd_data_r;
        state_nxt      = S_EMIT;
        if ((WB'(w_idx) == busiest_r) && (rd_data_r > thr_r)) begin
          if (move_cnt == '0) begin
            busiest_nxt = BUSY_NONE;
          end else begin
            shed_nxt     = rd_data_r;
            moves_nxt    = move_cnt;
            reb_nxt      = 1'b1;
            state_nxt    = S_RB_DEC;
          end
        end
      end

      S_RB_DEC: begin
        mem_we    = 1'b1;
        mem_wa    = w_idx;
        mem_wd    = shed_r - CNT_ONE;
        shed_nxt  = shed_r - CNT_ONE;
        state_nxt = S_CH_START;
      end

      S_CH_START: begin
        mem_re    = 1'b1;
        mem_ra    = hint_r;
        state_nxt = S_CH_HINT;
      end

      S_CH_HINT: begin
        pick_nxt = hint_r;
        best_nxt = rd_data_r;
        if (rd_data_r > CNT_ONE) begin
          mem_re    = 1'b1;
          mem_ra    = '0;
          idx_nxt   = '0;
          state_nxt = S_CH_SCAN;
        end else begin
          state_nxt = S_APPLY;
        end
      end

      S_CH_SCAN: begin
        if (rd_data_r == '0) begin
          // first empty worker wins outright
          pick_nxt  = idx_r;
          best_nxt  = '0;
          state_nxt = S_APPLY;
        end else begin
          if (rd_data_r < best_r) begin
            pick_nxt = idx_r;
            best_nxt = rd_data_r;
          end
          if (idx_r == IDX_LAST) begin
            state_nxt = S_APPLY;
          end else begin
            idx_nxt = idx_r + WI'(1);
            mem_re  = 1'b1;
            mem_ra  = idx_r + WI'(1);
          end
        end
      end

      S_APPLY: begin
        res_tw_nxt   = WRK_W'(pick_r);
        res_last_nxt = !reb_r || last_move;
        if (refuse) begin
          res_status_nxt = ST_REFUSED;
          res_tc_nxt     = best_r;
          if (reb_r) begin
            // refused move: task returns to the shedding worker
            mem_we   = 1'b1;
            mem_wa   = w_idx;
            mem_wd   = shed_r + CNT_ONE;
            shed_nxt = shed_r + CNT_ONE;
          end
        end else begin
          mem_we         = 1'b1;
          mem_wa         = pick_r;
          mem_wd         = best_r + CNT_ONE;
          res_status_nxt = reb_r ? ST_MOVED : ST_PLACED;
          res_tc_nxt     = best_r + CNT_ONE;
          if (reb_r && (pick_r == w_idx)) begin
            shed_nxt = best_r + CNT_ONE;
          end
        end
        if (reb_r) begin
          moves_nxt = moves_r - MV_W'(1);
        end
        if (last_move) begin
          busiest_nxt = BUSY_NONE;
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_tw_nxt     = res_tw_r;
          out_tc_nxt     = TCNT_W'(res_tc_r);
          out_busy_nxt   = BUSY_W'(busiest_r);
          out_last_nxt   = res_last_r;
          state_nxt      = res_last_r ? S_IDLE : S_RB_DEC;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= THR_RESET;
      hint_r      <= '0;
      busiest_r   <= BUSY_NONE;
      reb_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      thr_r       <= thr_nxt;
      hint_r      <= hint_nxt;
      busiest_r   <= busiest_nxt;
      reb_r       <= reb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    idx_r        <= idx_nxt;
    pick_r       <= pick_nxt;
    best_r       <= best_nxt;
    top_r        <= top_nxt;
    who_r        <= who_nxt;
    shed_r       <= shed_nxt;
    moves_r      <= moves_nxt;
    res_status_r <= res_status_nxt;
    res_tw_r     <= res_tw_nxt;
    res_tc_r     <= res_tc_nxt;
    res_last_r   <= res_last_nxt;
    out_status_r <= out_status_nxt;
    out_tw_r     <= out_tw_nxt;
    out_tc_r     <= out_tc_nxt;
    out_busy_r   <= out_busy_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_target_worker  = out_tw_r;
  assign out_target_count   = out_tc_r;
  assign out_busiest_worker = out_busy_r;
  assign out_last           = out_last_r;

endmodule

`default_nettype wire

// ===== src/lltd_checker.sv =====
// ============================================================================
// lltd_checker: port-level checks for the dispatcher
// Watches the result channel and the reset response; bound to the core.
// ============================================================================
`default_nettype none

module lltd_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [lltd_pkg::STAT_W-1:0]   out_status,
  input wire logic [lltd_pkg::WRK_W-1:0]    out_target_worker,
  input wire logic [lltd_pkg::TCNT_W-1:0]   out_target_count,
  input wire logic [lltd_pkg::BUSY_W-1:0]   out_busiest_worker,
  input wire logic                          out_last
);

  import lltd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_last)
      && $stable(out_target_worker) && $stable(out_target_count))
    else $error("stalled result changed");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // single-result requests always close their request
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_PLACED || out_status == ST_TAKEN
      || out_status == ST_IDLE || out_status == ST_NOREB) |-> out_last)
    else $error("single result without last");

  // a worker that went idle shows an empty count
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_IDLE) |-> (out_target_count == '0))
    else $error("went idle with nonzero count");

  // no status code beyond refused
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_REFUSED))
    else $error("bad status code");

endmodule

bind least_loaded_task_dispatcher_core lltd_checker u_lltd_checker (.*);

`default_nettype wire
